[sv/pxe_pkg.sv]
// ----------------------------------------------------------------------------
// pxe_pkg
// shared constants, token kinds, status codes and stack entry type of the expression
// evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package pxe_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int NUM_W       = 64;
    localparam int HALF_W      = NUM_W / 2;

    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef enum logic [2:0] {
        KIND_NUM   = 3'd0,
        KIND_ADD   = 3'd1,
        KIND_MUL   = 3'd2,
        KIND_OPEN  = 3'd3,
        KIND_CLOSE = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LENGTH   = 2'd1,
        STATUS_NOT_NUM  = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [NUM_W-1:0]   number;
    } entry_t;

endpackage

`default_nettype wire

[sv/pxe_if.sv]
// ----------------------------------------------------------------------------
// pxe_in_if / pxe_out_if
// valid/ready channels carrying text words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface pxe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_expression;

    modport source (output valid, output character, output end_of_expression, input ready);
    modport sink   (input valid, input character, input end_of_expression, output ready);
endinterface

interface pxe_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic        [1:0]  status;
    logic signed [63:0] running_total;

    modport source (output valid, output value, output status, output running_total,
                    input ready);
    modport sink   (input valid, input value, input status, input running_total,
                    output ready);
endinterface

`default_nettype wire

[sv/paren_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// paren_expression_evaluator
// shift-reduce evaluator of '+', '*' and parenthesised text, one byte a word
// ----------------------------------------------------------------------------
//
//  channel  dir  word fields                              handshake
//  text     in   character[7:0], end_of_expression        valid/ready
//  result   out  value[63:0] s, status[1:0], running_total valid/ready
//
//  a byte that only shifts, a skipped byte and an end word are handled in run
//  without leaving it; a reduction (num op num, or a closing parenthesis) goes
//  from run to fix, which finishes the split 64-bit multiply and refills the
//  cached second entry from a stack memory read port
//  a closing parenthesis that also completes num op num: run, fix, chk, fix
//  reset clears state, depth, overflow flag, running total and the output
//  valid flag; the stack memory is not cleared, entries are only read below
//  the depth
//  any text word waits while the output register holds a word that the
//  result side does not take in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module paren_expression_evaluator
    import pxe_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    pxe_in_if.sink      text,
    pxe_out_if.source   result
);

    // run: accept words; fix: finish reduction, refill second entry;
    // chk: a further num op num under the fresh top
    typedef enum logic [1:0] {
        ST_RUN,
        ST_FIX,
        ST_CHK
    } state_t;

    state_t               state_reg, state_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic                 ovf_reg, ovf_next;
    logic                 out_valid_reg, out_valid_next;
    logic [NUM_W-1:0]     total_reg, total_next;

    // cached top two entries, the rest sit in stack_mem below them
    entry_t               top_reg, top_next;
    entry_t               sec_reg, sec_next;
    logic [NUM_W-1:0]     out_value_reg, out_value_next;
    status_t              out_status_reg, out_status_next;

    // split multiply: low x low in full, cross terms low half only
    kind_t                op_reg;
    logic [NUM_W-1:0]     pp_ll_reg;
    logic [HALF_W-1:0]    pp_lh_reg;
    logic [HALF_W-1:0]    pp_hl_reg;
    logic [NUM_W-1:0]     add_reg;

    logic                 mul_load;
    logic [NUM_W-1:0]     mul_x, mul_y;
    kind_t                mul_op;

    // stack memory, one write port and two registered read ports
    entry_t               stack_mem [STACK_DEPTH];
    entry_t               rd_a_reg, rd_b_reg;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    entry_t               wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_a_addr, rd_b_addr;

    logic                 accept;
    logic                 is_blank;
    kind_t                new_kind;
    logic [NUM_W-1:0]     new_num;
    logic                 arith_match, paren_match;
    logic [HALF_W-1:0]    cross_sum;
    logic [NUM_W-1:0]     product;
    logic [NUM_W-1:0]     red_val;
    logic [NUM_W-1:0]     end_value;
    status_t              end_status;

    assign text.ready   = (state_reg == ST_RUN) && (!out_valid_reg || result.ready);
    assign accept       = text.valid && text.ready;

    assign result.valid         = out_valid_reg;
    assign result.value         = out_value_reg;
    assign result.status        = out_status_reg;
    assign result.running_total = total_reg;

    // token decode of the incoming byte
    always_comb
    begin
        is_blank = text.character inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
        new_num  = '0;
        case (text.character)
            CHAR_OPEN:  new_kind = KIND_OPEN;
            CHAR_CLOSE: new_kind = KIND_CLOSE;
            CHAR_PLUS:  new_kind = KIND_ADD;
            CHAR_STAR:  new_kind = KIND_MUL;
            default:
            begin
                new_kind = KIND_NUM;
                new_num  = NUM_W'(text.character) - NUM_W'(CHAR_ZERO);
            end
        endcase
    end

    // patterns over (second, top, incoming)
    assign arith_match = (sec_reg.kind == KIND_NUM)
                      && (top_reg.kind == KIND_ADD || top_reg.kind == KIND_MUL)
                      && (new_kind == KIND_NUM);
    assign paren_match = (sec_reg.kind == KIND_OPEN) && (top_reg.kind == KIND_NUM)
                      && (new_kind == KIND_CLOSE);

    // second multiply stage and result select
    assign cross_sum = pp_lh_reg + pp_hl_reg;
    assign product   = pp_ll_reg + {cross_sum, {HALF_W{1'b0}}};
    assign red_val   = (op_reg == KIND_MUL) ? product : add_reg;

    // end-of-expression checks, overflow first
    always_comb
    begin
        end_value = '0;
        if (ovf_reg)
            end_status = STATUS_OVERFLOW;
        else if (depth_reg != DEPTH_W'(1))
            end_status = STATUS_LENGTH;
        else if (top_reg.kind != KIND_NUM)
            end_status = STATUS_NOT_NUM;
        else
        begin
            end_status = STATUS_OK;
            end_value  = top_reg.number;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        ovf_next        = ovf_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        top_next        = top_reg;
        sec_next        = sec_reg;
        mul_load        = 1'b0;
        mul_x           = top_reg.number;
        mul_y           = '0;
        mul_op          = KIND_ADD;
        wr_en           = 1'b0;
        wr_addr         = ADDR_W'(depth_reg - DEPTH_W'(2));
        wr_data         = sec_reg;
        rd_en           = 1'b0;
        rd_a_addr       = ADDR_W'(depth_reg - DEPTH_W'(3));
        rd_b_addr       = ADDR_W'(depth_reg - DEPTH_W'(4));

        case (state_reg)
            ST_RUN:
            begin
                if (accept && text.end_of_expression)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = end_value;
                    out_status_next = end_status;
                    total_next      = total_reg + end_value;
                    depth_next      = '0;
                    ovf_next        = 1'b0;
                end
                else if (accept && !is_blank && !ovf_reg)
                begin
                    if (depth_reg == DEPTH_W'(STACK_DEPTH))
                        ovf_next = 1'b1;
                    else if (depth_reg >= DEPTH_W'(2) && (arith_match || paren_match))
                    begin
                        // reduce now, refill second entry from memory in fix
                        mul_load   = 1'b1;
                        mul_x      = arith_match ? sec_reg.number : top_reg.number;
                        mul_y      = arith_match ? new_num : '0;
                        mul_op     = arith_match ? top_reg.kind : KIND_ADD;
                        depth_next = depth_reg - DEPTH_W'(1);
                        rd_en      = 1'b1;
                        state_next = ST_FIX;
                    end
                    else
                    begin
                        // plain shift, second entry spills to memory
                        wr_en           = (depth_reg >= DEPTH_W'(2));
                        sec_next        = top_reg;
                        top_next.kind   = new_kind;
                        top_next.number = new_num;
                        depth_next      = depth_reg + DEPTH_W'(1);
                    end
                end
            end

            ST_FIX:
            begin
                top_next.kind   = KIND_NUM;
                top_next.number = red_val;
                if (depth_reg >= DEPTH_W'(3) && rd_b_reg.kind == KIND_NUM
                    && (rd_a_reg.kind == KIND_ADD || rd_a_reg.kind == KIND_MUL))
                    state_next = ST_CHK;
                else
                begin
                    if (depth_reg >= DEPTH_W'(2))
                        sec_next = rd_a_reg;
                    state_next = ST_RUN;
                end
            end

            ST_CHK:
            begin
                // num op num with the number from the closed parentheses
                mul_load   = 1'b1;
                mul_x      = rd_b_reg.number;
                mul_y      = top_reg.number;
                mul_op     = rd_a_reg.kind;
                depth_next = depth_reg - DEPTH_W'(2);
                rd_en      = 1'b1;
                rd_a_addr  = ADDR_W'(depth_reg - DEPTH_W'(4));
                rd_b_addr  = ADDR_W'(depth_reg - DEPTH_W'(5));
                state_next = ST_FIX;
            end

            default:
                state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            depth_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        sec_reg        <= sec_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        if (mul_load)
        begin
            pp_ll_reg <= NUM_W'(mul_x[HALF_W-1:0]) * NUM_W'(mul_y[HALF_W-1:0]);
            pp_lh_reg <= mul_x[HALF_W-1:0] * mul_y[NUM_W-1:HALF_W];
            pp_hl_reg <= mul_x[NUM_W-1:HALF_W] * mul_y[HALF_W-1:0];
            add_reg   <= mul_x + mul_y;
            op_reg    <= mul_op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_a_reg <= stack_mem[rd_a_addr];
            rd_b_reg <= stack_mem[rd_b_addr];
        end
    end

`ifndef ASSERT_OFF
    // an accepted end word always leaves a result word
    a_end_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text.end_of_expression |=> result.valid)
        else $error("end word produced no result word");

    // overflow only ever set on a full stack
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> depth_reg == DEPTH_W'(STACK_DEPTH))
        else $error("overflow flag without full stack");

    // a further reduction needs three entries
    a_chk_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHK |-> depth_reg >= DEPTH_W'(3))
        else $error("second reduction on a shallow stack");

    // chk always hands straight back to fix
    a_chk_to_fix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHK |=> state_reg == ST_FIX)
        else $error("chk not followed by fix");

    // no word taken while a reduction is in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIX |-> !text.ready && $past(mul_load))
        else $error("fix without a loaded reduction");
`endif

endmodule

`default_nettype wire

[test/expression_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// expression_result_checker
// watches the text and result channels of the expression evaluator, keeps its
// own token stack to work out every result word, and counts mismatches
// ----------------------------------------------------------------------------

module expression_result_checker
    import pxe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    pxe_in_if       text,
    pxe_out_if      result,
    output int      mismatches,
    output int      outstanding
);

    typedef struct {
        logic [NUM_W-1:0] value;
        status_t          status;
        logic [NUM_W-1:0] total;
    } outcome_t;

    kind_t            stack_kind [STACK_DEPTH];
    logic [NUM_W-1:0] stack_num  [STACK_DEPTH];
    int               stack_len;
    bit               overflow_seen;
    logic [NUM_W-1:0] total_so_far;
    outcome_t         awaited_outcomes[$];

    // space, or any of tab, line feed, vertical tab, form feed, carriage return
    function automatic bit is_blank(logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // collapse "num op num" and "( num )" at the top until neither fits
    function automatic void fold_stack();
        int a;
        int b;
        int t;
        while (stack_len >= 3) begin
            a = stack_len - 3;
            b = stack_len - 2;
            t = stack_len - 1;
            if (stack_kind[a] == KIND_NUM && stack_kind[t] == KIND_NUM &&
                (stack_kind[b] == KIND_ADD || stack_kind[b] == KIND_MUL)) begin
                stack_num[a] = (stack_kind[b] == KIND_ADD) ? stack_num[a] + stack_num[t]
                                                          : stack_num[a] * stack_num[t];
                stack_len -= 2;
            end
            else if (stack_kind[a] == KIND_OPEN && stack_kind[b] == KIND_NUM &&
                     stack_kind[t] == KIND_CLOSE) begin
                stack_kind[a] = KIND_NUM;
                stack_num[a]  = stack_num[b];
                stack_len -= 2;
            end
            else
                break;
        end
    endfunction

    function automatic void shift_byte(logic [7:0] c);
        kind_t            k;
        logic [NUM_W-1:0] n;
        if (overflow_seen || is_blank(c))
            return;
        n = '0;
        case (c)
            CHAR_OPEN:  k = KIND_OPEN;
            CHAR_CLOSE: k = KIND_CLOSE;
            CHAR_PLUS:  k = KIND_ADD;
            CHAR_STAR:  k = KIND_MUL;
            default:
            begin
                k = KIND_NUM;
                n = NUM_W'(c) - NUM_W'(CHAR_ZERO);
            end
        endcase
        if (stack_len >= STACK_DEPTH) begin
            overflow_seen = 1'b1;
            return;
        end
        stack_kind[stack_len] = k;
        stack_num[stack_len]  = n;
        stack_len++;
        fold_stack();
    endfunction

    function automatic void close_expression();
        outcome_t o;
        o.value = '0;
        if (overflow_seen)
            o.status = STATUS_OVERFLOW;
        else if (stack_len != 1)
            o.status = STATUS_LENGTH;
        else if (stack_kind[0] != KIND_NUM)
            o.status = STATUS_NOT_NUM;
        else
        begin
            o.status = STATUS_OK;
            o.value  = stack_num[0];
        end
        total_so_far += o.value;
        o.total = total_so_far;
        awaited_outcomes = {awaited_outcomes, o};
        stack_len     = 0;
        overflow_seen = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n) begin
            stack_len     = 0;
            overflow_seen = 1'b0;
            total_so_far  = '0;
            awaited_outcomes.delete();
            mismatches    = 0;
        end
        else
        begin
            if (result.valid && result.ready) begin
                if (awaited_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: value %0d status %0d total %0d",
                                 result.value, result.status, result.running_total);
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (result.value !== want.value || result.status !== want.status ||
                        result.running_total !== want.total) begin
                        mismatches++;
                        // value/status/total
                        if (mismatches <= 10)
                            $display("expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     $signed(want.value), want.status, $signed(want.total),
                                     result.value, result.status, result.running_total);
                    end
                end
            end
            if (text.valid && text.ready) begin
                if (text.end_of_expression)
                    close_expression();
                else
                    shift_byte(text.character);
            end
        end
        outstanding = awaited_outcomes.size();
    end

endmodule

[test/tb_paren_expression_evaluator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_paren_expression_evaluator
// feeds expression text to the evaluator a byte a word: a few hand-made
// expressions, then random well-formed, broken, overflowing and noisy ones,
// under three idling patterns; the checker beside the block predicts and
// compares every result word
// ----------------------------------------------------------------------------

module tb_paren_expression_evaluator;
    import pxe_pkg::*;

    localparam int WORDS_PER_PHASE = 600;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 20;

    logic clk;
    logic rst_n;

    pxe_in_if  text_ch ();
    pxe_out_if result_ch ();

    int mismatches;
    int outstanding;

    // idling odds in percent, one for the sending and one for the receiving process
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    int words_sent;

    // bytes of the expression being built, end word not included
    logic [7:0] text_bytes[$];

    paren_expression_evaluator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    expression_result_checker results_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .text        (text_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // expression builders
    // ------------------------------------------------------------------------

    // add one byte at the end of the text being built
    function automatic void append_byte(logic [7:0] b);
        text_bytes = {text_bytes, b};
    endfunction

    // space most of the time, otherwise one of the control blanks tab..cr
    function automatic logic [7:0] random_blank();
        if ($urandom_range(3) == 0)
            return CHAR_TAB + 8'($urandom_range(CHAR_CR - CHAR_TAB));
        return CHAR_SPACE;
    endfunction

    function automatic void sprinkle_blanks();
        while ($urandom_range(99) < 12)
            append_byte(random_blank());
    endfunction

    // mostly a decimal digit, sometimes any byte that is neither a token nor
    // a blank, so negative and large numbers turn up as well
    function automatic logic [7:0] random_number_byte();
        logic [7:0] b;
        if ($urandom_range(99) < 75)
            return CHAR_ZERO + 8'($urandom_range(9));
        do
            b = 8'($urandom_range(255));
        while (b inside {CHAR_OPEN, CHAR_CLOSE, CHAR_STAR, CHAR_PLUS, CHAR_SPACE} ||
               (b >= CHAR_TAB && b <= CHAR_CR));
        return b;
    endfunction

    // term { op term }, a term being a number or a bracketed sub-expression
    function automatic void build_expression(int nest);
        int terms;
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++) begin
            if (i > 0) begin
                sprinkle_blanks();
                append_byte($urandom_range(1) ? CHAR_PLUS : CHAR_STAR);
            end
            sprinkle_blanks();
            if (nest > 0 && $urandom_range(99) < 35) begin
                append_byte(CHAR_OPEN);
                build_expression(nest - 1);
                sprinkle_blanks();
                append_byte(CHAR_CLOSE);
            end
            else
                append_byte(random_number_byte());
        end
    endfunction

    function automatic void build_random_text();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 70)
            build_expression($urandom_range(5));
        else if (pick < 78) begin
            // long product of big numbers, wraps past 64 bits
            n = $urandom_range(8, 14);
            append_byte(8'($urandom_range(200, 255)));
            repeat (n) begin
                append_byte($urandom_range(7) == 0 ? CHAR_PLUS : CHAR_STAR);
                append_byte(8'($urandom_range(200, 255)));
            end
        end
        else if (pick < 86) begin
            // broken: tokens in no particular order
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(4))
                    0: append_byte(CHAR_OPEN);
                    1: append_byte(CHAR_CLOSE);
                    2: append_byte(CHAR_PLUS);
                    3: append_byte(CHAR_STAR);
                    default: append_byte(random_number_byte());
                endcase
                sprinkle_blanks();
            end
        end
        else if (pick < 91) begin
            repeat ($urandom_range(1, 8))
                append_byte(8'($urandom_range(255)));
        end
        else if (pick < 95) begin
            // tokens that never reduce, filling the stack close to, up to or past its top
            n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 8);
            repeat (n) begin
                case ($urandom_range(2))
                    0: append_byte(CHAR_OPEN);
                    1: append_byte(CHAR_PLUS);
                    default: append_byte(CHAR_STAR);
                endcase
            end
            repeat ($urandom_range(3))
                append_byte(random_number_byte());
        end
        else
        begin
            // empty text or one lone token
            case ($urandom_range(4))
                0: append_byte(CHAR_OPEN);
                1: append_byte(CHAR_CLOSE);
                2: append_byte(CHAR_PLUS);
                3: append_byte(CHAR_STAR);
                default: ;
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // text channel driver: changes at the falling edge, the word is taken at
    // the first rising edge that sees ready
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] c, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid             <= 1'b1;
        text_ch.character         <= c;
        text_ch.end_of_expression <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // send the built bytes and close with an end word carrying a random byte
    task automatic send_expression();
        foreach (text_bytes[i])
            send_word(text_bytes[i], 1'b0);
        send_word(8'($urandom_range(255)), 1'b1);
        text_bytes.delete();
    endtask

    // ------------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                     <= 1'b0;
        text_ch.valid             <= 1'b0;
        text_ch.character         <= '0;
        text_ch.end_of_expression <= 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b0;
        words_sent    = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:
                begin
                    send_idle_pct = 29;
                    recv_idle_pct = 58;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_idle_pct = 29;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase > 0) begin
                // sender pauses until every result so far has come back, then
                // the receiver holds off for a long stretch while text pours in
                @(negedge clk);
                text_ch.valid <= 1'b0;
                while (outstanding != 0)
                    @(negedge clk);
                hold_request = 1'b1;
            end
            else
            begin
                // empty expression: length error
                send_expression();
                // lone opening parenthesis: top is not a number
                text_bytes = '{CHAR_OPEN};
                send_expression();
                // dangling operator: length error
                text_bytes = '{CHAR_ZERO + 8'd1, CHAR_PLUS};
                send_expression();
                // lowest and highest bytes as numbers, -48 * 207
                text_bytes = '{8'h00, CHAR_STAR, 8'hFF};
                send_expression();
                // 2 * (3 + 4) with every kind of blank between the tokens
                text_bytes = '{CHAR_ZERO + 8'd2, CHAR_SPACE, CHAR_STAR, CHAR_TAB, CHAR_OPEN,
                               CHAR_ZERO + 8'd3, CHAR_TAB + 8'd1, CHAR_PLUS, CHAR_TAB + 8'd2,
                               CHAR_ZERO + 8'd4, CHAR_TAB + 8'd3, CHAR_CR, CHAR_CLOSE};
                send_expression();
            end

            while (words_sent < (phase + 1) * WORDS_PER_PHASE) begin
                build_random_text();
                send_expression();
            end
        end

        // all text taken: let the last results drain, the watchdog bounds this
        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result channel: random back-pressure, or a long hold when asked for
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long with no word moving on either channel
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
sv/pxe_pkg.sv
sv/pxe_if.sv
sv/paren_expression_evaluator.sv
test/expression_result_checker.sv
test/tb_paren_expression_evaluator.sv
